// File: sv/fsgs_pkg.sv
`default_nettype none

package fsgs_pkg;

   // command codes carried in the request
   localparam logic [1:0] CMD_PAINT = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam int unsigned SEED_WIDTH = 16;
   localparam logic [SEED_WIDTH-1:0] SEED_RESET = 16'd44257;
   localparam logic [SEED_WIDTH-1:0] LFSR_TAPS  = 16'hB400;

   // control from the sequencer to the direction lfsr
   typedef struct packed {
      logic load;
      logic advance;
   } lfsr_ctrl_type;

   // galois shift right, taps x^16+x^14+x^13+x^11+1
   function automatic logic [SEED_WIDTH-1:0] lfsr_next(input logic [SEED_WIDTH-1:0] s);
      logic [SEED_WIDTH-1:0] n;
      n = s >> 1;
      if (s[0]) begin
         n = n ^ LFSR_TAPS;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: sv/fsgs_ram.sv
`default_nettype none

module fsgs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: sv/fsgs_lfsr.sv
`default_nettype none

module fsgs_lfsr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fsgs_pkg::lfsr_ctrl_type              ctrl,
   input  wire logic [fsgs_pkg::SEED_WIDTH-1:0]      seed,
   output logic                                      choice
);

   logic [fsgs_pkg::SEED_WIDTH-1:0] state_ff;
   logic [fsgs_pkg::SEED_WIDTH-1:0] state_in;
   logic [fsgs_pkg::SEED_WIDTH-1:0] advanced;

   assign advanced = fsgs_pkg::lfsr_next(state_ff);
   // bit 0 of the advanced state, 0 picks left
   assign choice = advanced[0];

   always_comb begin
      state_in = state_ff;
      if (ctrl.load) begin
         // a zero seed would lock the register up
         state_in = (seed != '0) ? seed : fsgs_pkg::SEED_RESET;
      end else if (ctrl.advance) begin
         state_in = advanced;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsgs_pkg::SEED_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/falling_sand_grid_step_core.sv
// paint and read: the request transfer, a row fetch, then the result register;
// clear goes straight to the result. step: a sweep over the row pairs, bottom to top,
// with a column scan that updates one cell per cycle over each row pair.
// one command at a time; the next request is taken once the result is registered.
// reset (synchronous, active high) empties the grid through per-row valid bits at once,
// loads the seed register with 44257 and the lfsr with it; no clearing pass.
`default_nettype none

module falling_sand_grid_step_core #(
   parameter int ROWS = 64,
   parameter int COLS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // command[1:0], row[7:2], column[13:8], zero pad
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // cell_value[0], command_done[2:1], zero pad
   // seed register
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_FETCH = 8'b0000_0010,  // row data for paint / read arrives
      S_BELOW = 8'b0000_0100,  // bottom row arrives, fetch first upper row
      S_CUR   = 8'b0000_1000,  // upper row arrives
      S_SCAN  = 8'b0001_0000,  // one column per cycle
      S_WRITE = 8'b0010_0000,  // write back lower row, fetch next upper row
      S_LAST  = 8'b0100_0000,  // write back top row
      S_DONE  = 8'b1000_0000   // hand result to output register
   } state_type;

   // request fields
   logic [1:0] req_command;
   logic [5:0] req_row;
   logic [5:0] req_column;
   logic       req_inside;
   logic       req_xfer;

   assign req_command = req_tdata[1:0];
   assign req_row     = req_tdata[7:2];
   assign req_column  = req_tdata[13:8];
   assign req_inside  = ({3'b000, req_row} < 9'(ROWS)) && ({3'b000, req_column} < 9'(COLS));

   // control and payload registers
   state_type         state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [RW-1:0]     row_ff, row_in;        // addressed row, later the sweep row
   logic [CW-1:0]     col_ff, col_in;        // addressed column, later the scan column
   logic              inside_ff, inside_in;
   logic [COLS-1:0]   cur_ff, cur_in;        // row r during a sweep
   logic [COLS-1:0]   below_ff, below_in;    // row r+1 during a sweep
   logic [ROWS-1:0]   valid_ff, valid_in;    // row holds written data
   logic              rd_valid_ff;
   logic              value_ff, value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_value_ff, rsp_value_in;
   logic [1:0]        rsp_cmd_ff, rsp_cmd_in;
   logic [15:0]       seed_ff;

   // row memory
   logic              ram_we;
   logic [RW-1:0]     ram_waddr;
   logic [COLS-1:0]   ram_wdata;
   logic [RW-1:0]     ram_raddr;
   logic [COLS-1:0]   ram_rdata;
   logic [COLS-1:0]   row_data;

   fsgs_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // a row never written since reset or clear reads as empty
   assign row_data = rd_valid_ff ? ram_rdata : '0;

   // direction lfsr
   fsgs_pkg::lfsr_ctrl_type lfsr_ctrl;
   logic                    lfsr_choice;

   fsgs_lfsr u_lfsr (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lfsr_ctrl),
      .seed   (seed_ff),
      .choice (lfsr_choice)
   );

   // cell update at the scan column
   logic grain_here;
   logic free_down;
   logic free_left;
   logic free_right;
   logic both_free;
   logic go_left;
   logic last_col;

   assign last_col   = (col_ff == CW'(COLS - 1));
   assign grain_here = cur_ff[col_ff];
   assign free_down  = !below_ff[col_ff];
   // edge columns have no diagonal on their outer side
   assign free_left  = (col_ff != '0) && !below_ff[col_ff - 1'b1];
   assign free_right = !last_col && !below_ff[col_ff + 1'b1];
   assign both_free  = free_left && free_right;
   assign go_left    = free_left && (!free_right || !lfsr_choice);

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      inside_in     = inside_ff;
      cur_in        = cur_ff;
      below_in      = below_ff;
      valid_in      = valid_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      ram_we        = 1'b0;
      ram_waddr     = row_ff;
      ram_wdata     = row_data;
      ram_raddr     = '0;
      lfsr_ctrl     = '0;

      // result taken by the consumer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in    = req_command;
               row_in    = RW'(req_row);
               col_in    = CW'(req_column);
               inside_in = req_inside;
               value_in  = 1'b0;
               unique case (req_command) inside
                  fsgs_pkg::CMD_PAINT, fsgs_pkg::CMD_READ: begin
                     // outside the grid: paint is dropped, read gives 0
                     ram_raddr = RW'(req_row);
                     state_in  = req_inside ? S_FETCH : S_DONE;
                  end
                  fsgs_pkg::CMD_STEP: begin
                     ram_raddr = RW'(ROWS - 1);
                     row_in    = RW'(ROWS - 2);
                     state_in  = S_BELOW;
                  end
                  fsgs_pkg::CMD_CLEAR: begin
                     valid_in       = '0;
                     lfsr_ctrl.load = 1'b1;
                     state_in       = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_FETCH: begin
            if (cmd_ff == fsgs_pkg::CMD_PAINT) begin
               ram_we            = 1'b1;
               ram_waddr         = row_ff;
               ram_wdata         = row_data;
               ram_wdata[col_ff] = 1'b1;
               valid_in[row_ff]  = 1'b1;
            end else begin
               value_in = row_data[col_ff];
            end
            state_in = S_DONE;
         end

         S_BELOW: begin
            below_in  = row_data;
            ram_raddr = row_ff;
            state_in  = S_CUR;
         end

         S_CUR: begin
            cur_in   = row_data;
            col_in   = '0;
            state_in = S_SCAN;
         end

         S_SCAN: begin
            if (grain_here) begin
               if (free_down) begin
                  below_in[col_ff] = 1'b1;
                  cur_in[col_ff]   = 1'b0;
               end else if (free_left || free_right) begin
                  lfsr_ctrl.advance = both_free;
                  cur_in[col_ff]    = 1'b0;
                  if (go_left) begin
                     below_in[col_ff - 1'b1] = 1'b1;
                  end else begin
                     below_in[col_ff + 1'b1] = 1'b1;
                  end
               end
            end
            col_in = col_ff + 1'b1;
            if (last_col) begin
               state_in = S_WRITE;
            end
         end

         S_WRITE: begin
            // lower row is final once its upper neighbor is scanned
            ram_we                   = 1'b1;
            ram_waddr                = row_ff + 1'b1;
            ram_wdata                = below_ff;
            valid_in[row_ff + 1'b1]  = 1'b1;
            if (row_ff == '0) begin
               state_in = S_LAST;
            end else begin
               // the scanned row becomes the lower row of the next pair
               below_in  = cur_ff;
               ram_raddr = row_ff - 1'b1;
               row_in    = row_ff - 1'b1;
               state_in  = S_CUR;
            end
         end

         S_LAST: begin
            ram_we      = 1'b1;
            ram_waddr   = '0;
            ram_wdata   = cur_ff;
            valid_in[0] = 1'b1;
            state_in    = S_DONE;
         end

         S_DONE: begin
            // output register free or emptied this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_cmd_in   = cmd_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= fsgs_pkg::SEED_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      inside_ff    <= inside_in;
      cur_ff       <= cur_in;
      below_ff     <= below_in;
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rd_valid_ff  <= valid_ff[ram_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_cmd_ff, rsp_value_ff};

   // a clear transfer empties every row at once
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_command == fsgs_pkg::CMD_CLEAR)) |=> (valid_ff == '0))
      else $error("clear did not empty the grid");

   // row memory is written only by paint fetch and sweep write-back
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == S_FETCH) || (state_ff == S_WRITE) || (state_ff == S_LAST)))
      else $error("row write outside a write state");

   // a fetch is only entered for an address inside the grid
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> inside_ff)
      else $error("fetch for an address outside the grid");

   // a new result only comes from the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

endmodule

`default_nettype wire
